// ===== design/dau_pkg.sv =====
`default_nettype none

package dau_pkg;

  // angle accumulator counts units of 2^-20 degree
  localparam int ACC_FRAC     = 20;
  localparam int CORDIC_STEPS = 27;

  // bond vectors are kept below 2^29 in magnitude
  localparam int BOND_LIM_BIT = 29;
  localparam int BOND_W       = 30;
  // exact cross product of two bond vectors
  localparam int NRM_W        = 2 * BOND_W + 1;
  localparam int NRM_MAG_W    = NRM_W - 1;
  localparam int LEAD_W       = 6;
  // scaled normal: largest component magnitude in [2^27, 2^28)
  localparam int SCL_TOP      = 27;
  localparam int SCL_W        = 29;
  localparam int PRD_W        = 2 * SCL_W;
  // dot product, squared norms and norm product
  localparam int DOT_W        = 59;
  localparam int MAG_W        = 58;
  localparam int ROOT_W       = MAG_W / 2;
  // cosine magnitude in q1.30
  localparam int Q_FRAC       = 30;
  localparam int Q_W          = Q_FRAC + 1;
  localparam int SIN_IN_W     = 2 * Q_W;
  localparam int SIN_W        = SIN_IN_W / 2;
  // cordic datapath
  localparam int CX_W         = 34;
  localparam int Z_W          = 29;
  localparam int ATAN_W       = 27;

  localparam logic signed [Z_W-1:0] Z_DEG90  = Z_W'(90 <<< ACC_FRAC);
  localparam logic [Z_W-1:0]        Z_DEG180 = Z_W'(180 <<< ACC_FRAC);

  // atan(2^-i) in units of 2^-20 degree
  localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
    27'd1876857,  27'd938658,   27'd469357,   27'd234682,  27'd117342,
    27'd58671,    27'd29335,    27'd14668,    27'd7334,    27'd3667,
    27'd1833,     27'd917,      27'd458,      27'd229,     27'd115,
    27'd57,       27'd29,       27'd14,       27'd7,       27'd4,
    27'd2,        27'd1
  };

  // flags that ride along the back half of the pipeline
  typedef struct packed {
    logic degen;
    logic neg;
  } flags_t;

endpackage

`default_nettype wire

// ===== design/dihedral_angle_unit.sv =====
// throughput: one item per cycle unless the output stalls; the deepest parts are the
//   three root extractors, the 30-stage restoring divider and the 27-stage cordic
// a stall at the output holds every stage in place, nothing is dropped
// reset: asynchronous, active low, clears all valid bits; no clearing pass
`default_nettype none

module dihedral_angle_unit
  import dau_pkg::*;
#(
  parameter int COORD_WIDTH     = 24,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // p1_x, p1_y, p1_z, p2_x, ... p4_z, COORD_WIDTH bits each, zero padded
  input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata_i,
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // angle_degrees
  output logic [15:0]                                 m_axis_tdata_o,
  // degenerate
  output logic                                        m_axis_tuser_o,
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i
);

  localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic [Z_W-1:0] RND_HALF = Z_W'(1) << (RND_SH - 1);
  localparam logic [SIN_IN_W-1:0] SIN_ONE = SIN_IN_W'(1) << (2 * Q_FRAC);

  logic en;

  logic                    fr_vld, fr_degen;
  logic signed [DOT_W-1:0] fr_dot;
  logic [MAG_W-1:0]        fr_nsq1, fr_nsq2;

  logic                    r1_vld, r2_vld, r2_degen;
  logic [ROOT_W-1:0]       r1_root, r2_root;
  logic [DOT_W-1:0]        r1_dot;

  logic                    m_vld_q;
  logic [MAG_W-1:0]        m_prod_q, m_ad_q;
  flags_t                  m_flg_q;

  logic                    dv_vld;
  logic [Q_W-1:0]          dv_quo;
  flags_t                  dv_flg;

  logic                    sq_vld_q;
  logic [SIN_IN_W-1:0]     sq_val_q;
  logic [Q_W-1:0]          sq_q_q;
  flags_t                  sq_flg_q;
  logic [SIN_IN_W-1:0]     sin_rad;

  logic                    sn_vld;
  logic [SIN_W-1:0]        sn_root;
  logic [Q_W-1:0]          sn_q;
  flags_t                  sn_flg;

  logic                    cr_vld;
  logic signed [Z_W-1:0]   cr_z;
  flags_t                  cr_flg;

  logic [Z_W-1:0]          zf;
  logic [Z_W-1:0]          zr;
  logic [15:0]             ang_d;

  logic                    out_vld_q;
  logic [15:0]             out_ang_q;
  logic                    out_dg_q;

  // the whole pipeline advances unless a result waits at the output
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // bonds, normals, scaling, dot product and squared norms
  dau_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .coord_i (s_axis_tdata_i[12*COORD_WIDTH-1:0]),
    .valid_o (fr_vld),
    .degen_o (fr_degen),
    .dot_o   (fr_dot),
    .nsq1_o  (fr_nsq1),
    .nsq2_o  (fr_nsq2)
  );

  // norms of both normals
  dau_isqrt #(
    .IN_W  (MAG_W),
    .SIDE_W(DOT_W)
  ) u_norm1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .rad_i   (fr_nsq1),
    .side_i  (fr_dot),
    .valid_o (r1_vld),
    .root_o  (r1_root),
    .side_o  (r1_dot)
  );

  dau_isqrt #(
    .IN_W  (MAG_W),
    .SIDE_W(1)
  ) u_norm2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .rad_i   (fr_nsq2),
    .side_i  (fr_degen),
    .valid_o (r2_vld),
    .root_o  (r2_root),
    .side_o  (r2_degen)
  );

  // norm product and dot magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= r1_vld && r2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_prod_q      <= r1_root * r2_root;
      m_ad_q        <= r1_dot[DOT_W-1] ? MAG_W'(-$signed(r1_dot)) : MAG_W'(r1_dot);
      m_flg_q.neg   <= r1_dot[DOT_W-1];
      m_flg_q.degen <= r2_degen;
    end
  end

  // cosine magnitude in q1.30
  dau_div #(
    .SIDE_W($bits(flags_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_vld_q),
    .num_i   (m_ad_q),
    .den_i   (m_prod_q),
    .side_i  (m_flg_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_flg)
  );

  // square of the cosine for the sine term
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else if (en) begin
      sq_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_val_q <= dv_quo * dv_quo;
      sq_q_q   <= dv_quo;
      sq_flg_q <= dv_flg;
    end
  end

  assign sin_rad = SIN_ONE - sq_val_q;

  // sine in q1.30
  dau_isqrt #(
    .IN_W  (SIN_IN_W),
    .SIDE_W(Q_W + $bits(flags_t))
  ) u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld_q),
    .rad_i   (sin_rad),
    .side_i  ({sq_q_q, sq_flg_q}),
    .valid_o (sn_vld),
    .root_o  (sn_root),
    .side_o  ({sn_q, sn_flg})
  );

  dau_cordic #(
    .SIDE_W($bits(flags_t))
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sn_vld),
    .x_i     (sn_q),
    .y_i     (sn_root),
    .side_i  (sn_flg),
    .valid_o (cr_vld),
    .z_o     (cr_z),
    .side_o  (cr_flg)
  );

  // clamp to 0..90, fold for a negative cosine, round and saturate; zero if degenerate
  always_comb begin
    logic [Z_W-1:0] zc;
    logic [Z_W-1:0] ang_w;
    if (cr_z[Z_W-1]) begin
      zc = '0;
    end else if (cr_z > Z_DEG90) begin
      zc = Z_DEG90;
    end else begin
      zc = cr_z;
    end
    zf    = cr_flg.neg ? (Z_DEG180 - zc) : zc;
    zr    = zf + RND_HALF;
    ang_w = zr >> RND_SH;
    if (cr_flg.degen) begin
      ang_d = '0;
    end else if (|ang_w[Z_W-1:16]) begin
      ang_d = '1;
    end else begin
      ang_d = ang_w[15:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= cr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ang_q <= ang_d;
      out_dg_q  <= cr_flg.degen;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_ang_q;
  assign m_axis_tuser_o  = out_dg_q;

endmodule

`default_nettype wire

// ===== design/dau_isqrt.sv =====
`default_nettype none

module dau_isqrt
  import dau_pkg::*;
#(
  parameter int IN_W   = 58,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [IN_W-1:0]   rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [IN_W/2-1:0]      root_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int RW = IN_W / 2;

  logic              vld  [RW+1];
  logic [IN_W-1:0]   rad  [RW+1];
  logic [RW+1:0]     rem  [RW+1];
  logic [RW-1:0]     root [RW+1];
  logic [SIDE_W-1:0] side [RW+1];

  assign vld[0]  = valid_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_i;

  // one result bit per stage, two radicand bits brought down
  for (genvar s = 0; s < RW; s++) begin : g_stg
    logic [RW+1:0] remt;
    logic [RW+1:0] trial;

    assign remt  = {rem[s][RW-1:0], rad[s][IN_W-1 -: 2]};
    assign trial = {root[s], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad[s+1]  <= rad[s] << 2;
        side[s+1] <= side[s];
        if (remt >= trial) begin
          rem[s+1]  <= remt - trial;
          root[s+1] <= {root[s][RW-2:0], 1'b1};
        end else begin
          rem[s+1]  <= remt;
          root[s+1] <= {root[s][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld[RW];
  assign root_o  = root[RW];
  assign side_o  = side[RW];

endmodule

`default_nettype wire

// ===== design/dau_div.sv =====
`default_nettype none

module dau_div
  import dau_pkg::*;
#(
  parameter int SIDE_W = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [MAG_W-1:0]  num_i,
  input  wire logic [MAG_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [Q_W-1:0]         quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int N = Q_FRAC;

  logic              vld  [N+1];
  logic [MAG_W-1:0]  rem  [N+1];
  logic [MAG_W-1:0]  den  [N+1];
  logic [N-1:0]      quo  [N+1];
  logic              sat  [N+1];
  logic [SIDE_W-1:0] side [N+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = num_i;
  assign den[0]  = den_i;
  assign quo[0]  = '0;
  assign sat[0]  = (num_i >= den_i);
  assign side[0] = side_i;

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < N; s++) begin : g_stg
    logic [MAG_W:0] rs;
    logic [MAG_W:0] diff;

    assign rs   = {rem[s], 1'b0};
    assign diff = rs - {1'b0, den[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den[s+1]  <= den[s];
        sat[s+1]  <= sat[s];
        side[s+1] <= side[s];
        if (rs >= {1'b0, den[s]}) begin
          rem[s+1] <= diff[MAG_W-1:0];
          quo[s+1] <= {quo[s][N-2:0], 1'b1};
        end else begin
          rem[s+1] <= rs[MAG_W-1:0];
          quo[s+1] <= {quo[s][N-2:0], 1'b0};
        end
      end
    end
  end

  // quotient of one or more saturates to exactly one
  assign valid_o = vld[N];
  assign quo_o   = sat[N] ? (Q_W'(1) << Q_FRAC) : {1'b0, quo[N]};
  assign side_o  = side[N];

endmodule

`default_nettype wire

// ===== design/dau_cordic.sv =====
`default_nettype none

module dau_cordic
  import dau_pkg::*;
#(
  parameter int SIDE_W = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [Q_W-1:0]    x_i,
  input  wire logic [SIN_W-1:0]  y_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic signed [Z_W-1:0]  z_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int N = CORDIC_STEPS;

  logic                   vld  [N+1];
  logic signed [CX_W-1:0] xv   [N+1];
  logic signed [CX_W-1:0] yv   [N+1];
  logic signed [Z_W-1:0]  zv   [N+1];
  logic [SIDE_W-1:0]      side [N+1];

  assign vld[0]  = valid_i;
  assign xv[0]   = $signed(CX_W'(x_i));
  assign yv[0]   = $signed(CX_W'(y_i));
  assign zv[0]   = '0;
  assign side[0] = side_i;

  // vectoring mode, one micro-rotation per stage
  for (genvar s = 0; s < N; s++) begin : g_stg
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic signed [Z_W-1:0]  at;

    assign xs = xv[s] >>> s;
    assign ys = yv[s] >>> s;
    assign at = $signed(Z_W'(ATAN_TAB[s]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side[s+1] <= side[s];
        if (!yv[s][CX_W-1]) begin
          xv[s+1] <= xv[s] + ys;
          yv[s+1] <= yv[s] - xs;
          zv[s+1] <= zv[s] + at;
        end else begin
          xv[s+1] <= xv[s] - ys;
          yv[s+1] <= yv[s] + xs;
          zv[s+1] <= zv[s] - at;
        end
      end
    end
  end

  assign valid_o = vld[N];
  assign z_o     = zv[N];
  assign side_o  = side[N];

endmodule

`default_nettype wire

// ===== design/dau_front.sv =====
`default_nettype none

module dau_front
  import dau_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [11:0][COORD_WIDTH-1:0] coord_i,
  output logic                              valid_o,
  output logic                              degen_o,
  output logic signed [DOT_W-1:0]           dot_o,
  output logic [MAG_W-1:0]                  nsq1_o,
  output logic [MAG_W-1:0]                  nsq2_o
);

  localparam int BW = COORD_WIDTH + 1;
  localparam int EW = (BW > BOND_W) ? BW : BOND_W;
  localparam int NS = 9;

  logic [NS-1:0] vld_q;

  logic signed [BW-1:0]       bnd_d   [9];
  logic signed [BW-1:0]       bnd_q   [9];
  logic signed [BOND_W-1:0]   bsh_d   [9];
  logic signed [BOND_W-1:0]   bsh_q   [9];
  logic [BW-1:0]              bmag_or;
  logic [2:0]                 bsh_amt;
  logic signed [2*BOND_W-1:0] prod_d  [2][3][2];
  logic signed [2*BOND_W-1:0] prod_q  [2][3][2];
  logic signed [NRM_W-1:0]    nrm_d_q [2][3];
  logic signed [NRM_W-1:0]    nrm_e_q [2][3];
  logic signed [NRM_W-1:0]    nrm_f_q [2][3];
  logic [NRM_MAG_W-1:0]       nor_d   [2];
  logic [NRM_MAG_W-1:0]       nor_q   [2];
  logic [LEAD_W-1:0]          lead_d  [2];
  logic [LEAD_W-1:0]          lead_q  [2];
  logic signed [SCL_W-1:0]    scl_d   [2][3];
  logic signed [SCL_W-1:0]    scl_q   [2][3];
  logic signed [PRD_W-1:0]    dprd_q  [3];
  logic signed [PRD_W-1:0]    sq_q    [2][3];
  logic                       degen_d;
  logic                       dg_e_q, dg_f_q, dg_g_q, dg_h_q, dg_i_q;
  logic signed [DOT_W-1:0]    dot_q;
  logic [MAG_W-1:0]           nsq_q   [2];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  // bond vectors as exact differences
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        bnd_d[i*3+j] = $signed({coord_i[(i+1)*3+j][COORD_WIDTH-1], coord_i[(i+1)*3+j]})
                     - $signed({coord_i[i*3+j][COORD_WIDTH-1], coord_i[i*3+j]});
      end
    end
  end

  // common right shift that keeps every bond component below the limit
  always_comb begin
    logic signed [EW-1:0] ext;
    bmag_or = '0;
    for (int k = 0; k < 9; k++) begin
      bmag_or = bmag_or | (bnd_q[k][BW-1] ? BW'(-bnd_q[k]) : BW'(bnd_q[k]));
    end
    bsh_amt = '0;
    for (int k = BOND_LIM_BIT; k < BW; k++) begin
      if (bmag_or[k]) begin
        bsh_amt = 3'(k - BOND_LIM_BIT + 1);
      end
    end
    for (int k = 0; k < 9; k++) begin
      ext      = EW'(bnd_q[k]) >>> bsh_amt;
      bsh_d[k] = ext[BOND_W-1:0];
    end
  end

  // partial products of both cross products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int n = 0; n < 2; n++) begin
        prod_d[n][c][0] = bsh_q[n*3 + (c+1)%3] * bsh_q[(n+1)*3 + (c+2)%3];
        prod_d[n][c][1] = bsh_q[n*3 + (c+2)%3] * bsh_q[(n+1)*3 + (c+1)%3];
      end
    end
  end

  // degenerate check and magnitude envelope of each normal
  always_comb begin
    logic z0, z1;
    z0 = 1'b1;
    z1 = 1'b1;
    for (int n = 0; n < 2; n++) begin
      nor_d[n] = '0;
      for (int c = 0; c < 3; c++) begin
        nor_d[n] = nor_d[n] | (nrm_d_q[n][c][NRM_W-1] ? NRM_MAG_W'(-nrm_d_q[n][c])
                                                      : NRM_MAG_W'(nrm_d_q[n][c]));
      end
    end
    for (int c = 0; c < 3; c++) begin
      z0 = z0 & (nrm_d_q[0][c] == '0);
      z1 = z1 & (nrm_d_q[1][c] == '0);
    end
    degen_d = z0 | z1;
  end

  // leading one of each envelope
  always_comb begin
    for (int n = 0; n < 2; n++) begin
      lead_d[n] = '0;
      for (int k = 0; k < NRM_MAG_W; k++) begin
        if (nor_q[n][k]) begin
          lead_d[n] = LEAD_W'(k);
        end
      end
    end
  end

  // power-of-two scaling to put the leading one at bit 27
  always_comb begin
    logic signed [NRM_W-1:0] t;
    for (int n = 0; n < 2; n++) begin
      for (int c = 0; c < 3; c++) begin
        if (lead_q[n] >= LEAD_W'(SCL_TOP)) begin
          t = nrm_f_q[n][c] >>> (lead_q[n] - LEAD_W'(SCL_TOP));
        end else begin
          t = nrm_f_q[n][c] <<< (LEAD_W'(SCL_TOP) - lead_q[n]);
        end
        scl_d[n][c] = t[SCL_W-1:0];
      end
    end
  end

  // data registers, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bnd_q   <= bnd_d;
      bsh_q   <= bsh_d;
      prod_q  <= prod_d;
      for (int n = 0; n < 2; n++) begin
        for (int c = 0; c < 3; c++) begin
          nrm_d_q[n][c] <= NRM_W'(prod_q[n][c][0]) - NRM_W'(prod_q[n][c][1]);
          sq_q[n][c]    <= scl_q[n][c] * scl_q[n][c];
        end
        nsq_q[n] <= MAG_W'($unsigned(sq_q[n][0])) + MAG_W'($unsigned(sq_q[n][1]))
                  + MAG_W'($unsigned(sq_q[n][2]));
      end
      for (int c = 0; c < 3; c++) begin
        dprd_q[c] <= scl_q[0][c] * scl_q[1][c];
      end
      dot_q   <= DOT_W'(dprd_q[0]) + DOT_W'(dprd_q[1]) + DOT_W'(dprd_q[2]);
      nrm_e_q <= nrm_d_q;
      nor_q   <= nor_d;
      dg_e_q  <= degen_d;
      nrm_f_q <= nrm_e_q;
      lead_q  <= lead_d;
      dg_f_q  <= dg_e_q;
      scl_q   <= scl_d;
      dg_g_q  <= dg_f_q;
      dg_h_q  <= dg_g_q;
      dg_i_q  <= dg_h_q;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign degen_o = dg_i_q;
  assign dot_o   = dot_q;
  assign nsq1_o  = nsq_q[0];
  assign nsq2_o  = nsq_q[1];

endmodule

`default_nettype wire
